>>> design/sample_frame_hex_emitter_unit_defines.svh
// Assertion macros for the sample frame hex emitter.
// Included by the RTL files that carry concurrent assertions.
`ifndef SAMPLE_FRAME_HEX_EMITTER_UNIT_DEFINES_SVH
`define SAMPLE_FRAME_HEX_EMITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SFHE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sfhe_pkg.sv
// Shared types, constants and helpers for the sample frame hex emitter.
// No dependencies.
`timescale 1ns / 1ps

package sfhe_pkg;

    localparam logic [7:0]  SYNC0         = 8'h55;
    localparam logic [7:0]  SYNC1         = 8'hAA;
    localparam logic [7:0]  PAYLOAD_LEN   = 8'h07;
    localparam logic [7:0]  CMD_CODE      = 8'h00;
    localparam logic [15:0] CHK_SEED      = 16'hA5A5;
    localparam logic [15:0] CHK_XOR       = 16'h1021;

    localparam logic [3:0]  CHECKED_BYTES = 4'd11;
    localparam logic [3:0]  LAST_BYTE     = 4'd12;
    localparam logic [3:0]  LF_SLOT       = 4'd13;

    localparam logic [6:0]  CHAR_SP       = 7'h20;
    localparam logic [6:0]  CHAR_CR       = 7'h0D;
    localparam logic [6:0]  CHAR_LF       = 7'h0A;

    localparam logic [6:0]  HEX_TABLE [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

    typedef enum logic [1:0] {
        POS_HI,
        POS_LO,
        POS_SEP
    } pos_t;

    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        logic [7:0] data;
    } step_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        return HEX_TABLE[nib];
    endfunction

endpackage

>>> design/sfhe_check.sv
// Frame check accumulator: one byte folded in per step.
// Depends on sfhe_pkg.
`timescale 1ns / 1ps

module sfhe_check
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sfhe_pkg::step_t    step,
    output logic [15:0]        chk
);

    logic [15:0] chk_reg;
    logic [15:0] chk_next;
    logic [15:0] sum;
    logic [15:0] rot;

    always_comb
    begin
        sum      = chk_reg + {8'h00, step.data};
        rot      = {sum[14:0], sum[15]};
        chk_next = chk_reg;
        if (load)
        begin
            chk_next = sfhe_pkg::CHK_SEED;
        end
        else if (step.en)
        begin
            chk_next = rot ^ (sfhe_pkg::CHK_XOR + {12'h000, step.idx});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_reg <= sfhe_pkg::CHK_SEED;
        end
        else
        begin
            chk_reg <= chk_next;
        end
    end

    assign chk = chk_reg;

endmodule

>>> design/sfhe_emit.sv
// Frame holder and character sequencer: one ASCII word per cycle.
// Depends on sfhe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sample_frame_hex_emitter_unit_defines.svh"

module sfhe_emit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [7:0]         channel_address,
    input  logic [15:0]        sample_value,
    input  logic [31:0]        time_stamp,
    input  logic [15:0]        chk,
    output sfhe_pkg::step_t    step,
    output logic               busy,
    output logic [6:0]         text_char,
    output logic               last_char,
    output logic               strobe
);

    logic [7:0]     addr_reg;
    logic [15:0]    samp_reg;
    logic [31:0]    ts_reg;

    logic           active_reg;
    logic           active_next;
    logic [3:0]     byte_reg;
    logic [3:0]     byte_next;
    sfhe_pkg::pos_t pos_reg;
    sfhe_pkg::pos_t pos_next;

    logic [6:0]     text_reg;
    logic [6:0]     text_next;
    logic           last_reg;
    logic           strobe_reg;

    logic [7:0]     cur_byte;

    always_comb
    begin
        case (byte_reg)
            4'd0:    cur_byte = sfhe_pkg::SYNC0;
            4'd1:    cur_byte = sfhe_pkg::SYNC1;
            4'd2:    cur_byte = addr_reg;
            4'd3:    cur_byte = sfhe_pkg::PAYLOAD_LEN;
            4'd4:    cur_byte = sfhe_pkg::CMD_CODE;
            4'd5:    cur_byte = samp_reg[7:0];
            4'd6:    cur_byte = samp_reg[15:8];
            4'd7:    cur_byte = ts_reg[7:0];
            4'd8:    cur_byte = ts_reg[15:8];
            4'd9:    cur_byte = ts_reg[23:16];
            4'd10:   cur_byte = ts_reg[31:24];
            4'd11:   cur_byte = chk[7:0];
            4'd12:   cur_byte = chk[15:8];
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        if (byte_reg == sfhe_pkg::LF_SLOT)
        begin
            text_next = sfhe_pkg::CHAR_LF;
        end
        else
        begin
            unique case (pos_reg)
                sfhe_pkg::POS_HI:  text_next = sfhe_pkg::hex_char(cur_byte[7:4]);
                sfhe_pkg::POS_LO:  text_next = sfhe_pkg::hex_char(cur_byte[3:0]);
                sfhe_pkg::POS_SEP: text_next = (byte_reg == sfhe_pkg::LAST_BYTE) ?
                                               sfhe_pkg::CHAR_CR : sfhe_pkg::CHAR_SP;
                default:           text_next = sfhe_pkg::CHAR_SP;
            endcase
        end
    end

    // Advance through hi digit, lo digit, separator for each byte; LF slot ends the frame.
    always_comb
    begin
        active_next = active_reg;
        byte_next   = byte_reg;
        pos_next    = pos_reg;
        if (load)
        begin
            active_next = 1'b1;
            byte_next   = 4'd0;
            pos_next    = sfhe_pkg::POS_HI;
        end
        else if (active_reg)
        begin
            if (byte_reg == sfhe_pkg::LF_SLOT)
            begin
                active_next = 1'b0;
            end
            else
            begin
                unique case (pos_reg)
                    sfhe_pkg::POS_HI:  pos_next = sfhe_pkg::POS_LO;
                    sfhe_pkg::POS_LO:  pos_next = sfhe_pkg::POS_SEP;
                    sfhe_pkg::POS_SEP:
                    begin
                        pos_next  = sfhe_pkg::POS_HI;
                        byte_next = byte_reg + 4'd1;
                    end
                    default:           pos_next = sfhe_pkg::POS_HI;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= channel_address;
            samp_reg <= sample_value;
            ts_reg   <= time_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            byte_reg   <= 4'd0;
            pos_reg    <= sfhe_pkg::POS_HI;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            text_reg   <= sfhe_pkg::CHAR_SP;
        end
        else
        begin
            active_reg <= active_next;
            byte_reg   <= byte_next;
            pos_reg    <= pos_next;
            strobe_reg <= active_reg;
            last_reg   <= active_reg && (byte_reg == sfhe_pkg::LF_SLOT);
            text_reg   <= text_next;
        end
    end

    assign step.en   = active_reg && (pos_reg == sfhe_pkg::POS_HI) &&
                       (byte_reg < sfhe_pkg::CHECKED_BYTES);
    assign step.idx  = byte_reg;
    assign step.data = cur_byte;

    assign busy      = active_reg && (byte_reg != sfhe_pkg::LF_SLOT);
    assign text_char = text_reg;
    assign last_char = last_reg;
    assign strobe    = strobe_reg;

    `SFHE_ASSERT_NOW(a_last_has_strobe, clk, rst_n, last_reg, strobe_reg, "last without strobe")
    `SFHE_ASSERT_NEXT(a_load_restarts, clk, rst_n, load, active_reg && (byte_reg == 4'd0) && (pos_reg == sfhe_pkg::POS_HI), "load did not restart frame")
    `SFHE_ASSERT_NEXT(a_lf_ends_frame, clk, rst_n, active_reg && (byte_reg == sfhe_pkg::LF_SLOT) && !load, !active_reg && last_reg && (text_reg == sfhe_pkg::CHAR_LF), "frame did not end on LF")
    `SFHE_ASSERT_NEXT(a_cr_after_check, clk, rst_n, active_reg && (byte_reg == sfhe_pkg::LAST_BYTE) && (pos_reg == sfhe_pkg::POS_SEP), strobe_reg && (text_reg == sfhe_pkg::CHAR_CR), "missing CR after check byte")

endmodule

>>> design/sample_frame_hex_emitter_unit.sv
// The first character strobes from the output registers, behind the active register that an accepted reading sets.
// Each reading emits 40 characters, one per cycle, with no gaps.
// A new reading is accepted in the cycle the LF is formed, so frames can run back to back.
// The receiver cannot stall: the unit has no ready input.
// Reset (rst_n low, asynchronous) idles the sequencer; no strobe until a reading.
// Top level; depends on sfhe_pkg, sfhe_check and sfhe_emit.
`timescale 1ns / 1ps

module sample_frame_hex_emitter_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  channel_address,
    input  logic [15:0] sample_value,
    input  logic [31:0] time_stamp,
    output logic        strobe,
    output logic [6:0]  text_char,
    output logic        last_char
);

    logic            load;
    logic            emit_busy;
    logic [15:0]     chk;
    sfhe_pkg::step_t step;

    assign load = start && !emit_busy;
    assign busy = emit_busy;

    sfhe_check u_check
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .step  (step),
        .chk   (chk)
    );

    sfhe_emit u_emit
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (load),
        .channel_address (channel_address),
        .sample_value    (sample_value),
        .time_stamp      (time_stamp),
        .chk             (chk),
        .step            (step),
        .busy            (emit_busy),
        .text_char       (text_char),
        .last_char       (last_char),
        .strobe          (strobe)
    );

endmodule

>>> tb/tb.sv
// Testbench for sample_frame_hex_emitter_unit: builds each expected 40-character hex frame
// from the reading it sends and checks every strobed character against it, in order.
// Depends on sfhe_pkg and the sample_frame_hex_emitter_unit RTL.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        logic [6:0] ch;
        logic       last;
    } text_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [7:0]  channel_address = '0;
    logic [15:0] sample_value = '0;
    logic [31:0] time_stamp = '0;
    logic        strobe;
    logic [6:0]  text_char;
    logic        last_char;

    text_word_t  expected_chars[$];
    text_word_t  want;
    int          errors = 0;
    int          idle_cycles = 0;

    sample_frame_hex_emitter_unit u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .channel_address (channel_address),
        .sample_value    (sample_value),
        .time_stamp      (time_stamp),
        .strobe          (strobe),
        .text_char       (text_char),
        .last_char       (last_char)
    );

    always #4 clk = ~clk;

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10)
            return 7'h30 + {3'b000, nib};
        return 7'h41 + {3'b000, nib} - 7'd10;
    endfunction

    function automatic void push_frame_text(input logic [7:0] addr, input logic [15:0] samp,
                                            input logic [31:0] ts);
        logic [7:0]  frame [13];
        logic [15:0] chk;
        text_word_t  w;
        frame[0]  = sfhe_pkg::SYNC0;
        frame[1]  = sfhe_pkg::SYNC1;
        frame[2]  = addr;
        frame[3]  = sfhe_pkg::PAYLOAD_LEN;
        frame[4]  = sfhe_pkg::CMD_CODE;
        frame[5]  = samp[7:0];
        frame[6]  = samp[15:8];
        frame[7]  = ts[7:0];
        frame[8]  = ts[15:8];
        frame[9]  = ts[23:16];
        frame[10] = ts[31:24];
        chk = sfhe_pkg::CHK_SEED;
        for (int i = 0; i < 11; i++)
        begin
            chk = chk + {8'h00, frame[i]};
            chk = {chk[14:0], chk[15]};
            chk = chk ^ (sfhe_pkg::CHK_XOR + 16'(i));
        end
        frame[11] = chk[7:0];
        frame[12] = chk[15:8];
        w.last = 1'b0;
        for (int b = 0; b < 13; b++)
        begin
            w.ch = hex_digit(frame[b][7:4]);
            expected_chars.push_back(w);
            w.ch = hex_digit(frame[b][3:0]);
            expected_chars.push_back(w);
            w.ch = (b == 12) ? sfhe_pkg::CHAR_CR : sfhe_pkg::CHAR_SP;
            expected_chars.push_back(w);
        end
        w.ch = sfhe_pkg::CHAR_LF;
        w.last = 1'b1;
        expected_chars.push_back(w);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_reading(input logic [7:0] addr, input logic [15:0] samp,
                                input logic [31:0] ts, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            channel_address <= 8'($urandom);
            sample_value <= 16'($urandom);
            time_stamp <= 32'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        channel_address <= addr;
        sample_value <= samp;
        time_stamp <= ts;
        do
            @(posedge clk);
        while (busy);
        push_frame_text(addr, samp, ts);
    endtask

    task automatic wait_drained();
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extremes();
        send_reading(8'h00, 16'h0000, 32'h0000_0000, 0);
        send_reading(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_reading(8'hAA, 16'hAAAA, 32'hAAAA_AAAA, 1);
        send_reading(8'h55, 16'h5555, 32'h5555_5555, 0);
        send_reading(8'hFF, 16'h0000, 32'h0000_0000, 0);
        send_reading(8'h00, 16'hFFFF, 32'h0000_0000, 2);
        send_reading(8'h00, 16'h0000, 32'hFFFF_FFFF, 0);
        send_reading(8'h7F, 16'h8000, 32'h8000_0000, 0);
    endtask

    task automatic test_bit_walk();
        for (int k = 0; k < 8; k++)
            send_reading(8'(1 << k), 16'(1 << (2 * k)), 32'(1 << (4 * k)), k % 3);
    endtask

    // Hold the sender until the whole frame backlog has gone out.
    task automatic test_drain_pause();
        for (int n = 0; n < 4; n++)
            send_reading(8'($urandom), 16'($urandom), 32'($urandom), 0);
        start <= 1'b0;
        wait_drained();
        @(posedge clk);
        for (int n = 0; n < 4; n++)
            send_reading(8'($urandom), 16'($urandom), 32'($urandom), 0);
    endtask

    task automatic test_back_to_back();
        for (int n = 0; n < 30; n++)
            send_reading(8'($urandom), 16'($urandom), 32'($urandom), 0);
    endtask

    task automatic test_random();
        logic [7:0]  addr;
        logic [15:0] samp;
        logic [31:0] ts;
        for (int n = 0; n < 450; n++)
        begin
            addr = 8'($urandom);
            samp = 16'($urandom);
            ts = 32'($urandom);
            case ($urandom_range(0, 9))
                0: addr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                1: samp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                2: ts = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
                default: ;
            endcase
            send_reading(addr, samp, ts, (n % 100 < 15) ? 0 : pick_gap());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual char %h last %b",
                         $time, text_char, last_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (text_char !== want.ch)
                begin
                    errors++;
                    $display("%0t: text_char mismatch: expected %h, actual %h",
                             $time, want.ch, text_char);
                end
                if (last_char !== want.last)
                begin
                    errors++;
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, want.last, last_char);
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || strobe))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_bit_walk();
        test_drain_pause();
        test_back_to_back();
        test_random();
        start <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_chars.size() != 0)
        begin
            errors++;
            $display("%0t: frame text left over: expected %0d more words, actual 0",
                     $time, expected_chars.size());
        end
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/sfhe_pkg.sv
design/sfhe_check.sv
design/sfhe_emit.sv
design/sample_frame_hex_emitter_unit.sv
tb/tb.sv
